/* src/wmps_pkg.sv */
// Shared constants and types for the wildcard multi-pattern scanner.
// Used by every module under src; no dependencies of its own.
package wmps_pkg;

  localparam int DEF_MAX_PATTERN_BYTES = 8;
  localparam int DEF_NUM_PATTERNS      = 4;
  localparam int DEF_OFFSET_BITS       = 32;

  // Fixed register and field widths.
  localparam int PATTERN_SLOTS  = 4;
  localparam int PATTERN_BITS   = 64;
  localparam int LEN_BITS       = 4;
  localparam int LENGTHS_BITS   = 16;
  localparam int COUNT_BITS     = 3;
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 64;
  localparam int MASK_BITS      = 4;
  localparam int OUT_OFFSET_BITS = 32;

  localparam logic [7:0] WILDCARD_BYTE = 8'h3F;

  // Register indexes on the config port.
  localparam logic [CFG_INDEX_BITS-1:0] CFG_IDX_PATTERN_ZERO  = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_IDX_PATTERN_ONE   = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_IDX_PATTERN_TWO   = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_IDX_PATTERN_THREE = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_IDX_LENGTHS       = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_IDX_COUNT         = 3'd5;

  typedef struct packed {
    logic [PATTERN_SLOTS-1:0][PATTERN_BITS-1:0] patterns;
    logic [LENGTHS_BITS-1:0]                    lengths;
    logic [COUNT_BITS-1:0]                      count;
  } cfg_bundle_t;

  typedef struct packed {
    logic                       hit;
    logic [MASK_BITS-1:0]       mask;
    logic [OUT_OFFSET_BITS-1:0] offset;
  } match_result_t;

endpackage

/* src/wmps_cfg_regs.sv */
// Configuration register file: pattern bytes, lengths and active count.
// Depends on wmps_pkg.
module wmps_cfg_regs #(
  parameter int NUM_PATTERNS = wmps_pkg::DEF_NUM_PATTERNS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [wmps_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [wmps_pkg::CFG_DATA_BITS-1:0]  cfg_wdata,
  output wmps_pkg::cfg_bundle_t               cfg
);

  logic [wmps_pkg::PATTERN_SLOTS-1:0][wmps_pkg::PATTERN_BITS-1:0] patterns_r, patterns_nxt;
  logic [wmps_pkg::LENGTHS_BITS-1:0] lengths_r, lengths_nxt;
  logic [wmps_pkg::COUNT_BITS-1:0]   count_r, count_nxt;

  always_comb begin
    patterns_nxt = patterns_r;
    lengths_nxt  = lengths_r;
    count_nxt    = count_r;
    if (cfg_we) begin
      case (cfg_index)
        wmps_pkg::CFG_IDX_PATTERN_ZERO,
        wmps_pkg::CFG_IDX_PATTERN_ONE,
        wmps_pkg::CFG_IDX_PATTERN_TWO,
        wmps_pkg::CFG_IDX_PATTERN_THREE: begin
          // slots past NUM_PATTERNS are never read; keep them at zero
          if (32'(cfg_index) < 32'(NUM_PATTERNS)) begin
            patterns_nxt[cfg_index[1:0]] = cfg_wdata[wmps_pkg::PATTERN_BITS-1:0];
          end
        end
        wmps_pkg::CFG_IDX_LENGTHS: lengths_nxt = cfg_wdata[wmps_pkg::LENGTHS_BITS-1:0];
        wmps_pkg::CFG_IDX_COUNT:   count_nxt   = cfg_wdata[wmps_pkg::COUNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      patterns_r <= '0;
      lengths_r  <= '0;
      count_r    <= '0;
    end else begin
      patterns_r <= patterns_nxt;
      lengths_r  <= lengths_nxt;
      count_r    <= count_nxt;
    end
  end

  assign cfg.patterns = patterns_r;
  assign cfg.lengths  = lengths_r;
  assign cfg.count    = count_r;

endmodule

/* src/wmps_window.sv */
// Byte window shift line and saturating byte counter of the current buffer.
// Depends on wmps_pkg.
module wmps_window #(
  parameter int MAX_PATTERN_BYTES = wmps_pkg::DEF_MAX_PATTERN_BYTES,
  parameter int OFFSET_BITS       = wmps_pkg::DEF_OFFSET_BITS
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               accept,
  input  logic [7:0]                         data_byte,
  input  logic                               start_of_buffer,
  output logic [MAX_PATTERN_BYTES-1:0][7:0]  window,
  output logic [OFFSET_BITS-1:0]             bytes_seen
);

  logic [MAX_PATTERN_BYTES-1:0][7:0] window_r, window_nxt;
  logic [OFFSET_BITS-1:0]            seen_r, seen_nxt;
  logic [OFFSET_BITS-1:0]            seen_base;

  always_comb begin
    window_nxt = window_r;
    seen_nxt   = seen_r;
    seen_base  = start_of_buffer ? '0 : seen_r;
    if (accept) begin
      // entry 0 holds the newest byte
      for (int i = MAX_PATTERN_BYTES - 1; i > 0; i--) begin
        window_nxt[i] = window_r[i-1];
      end
      window_nxt[0] = data_byte;
      seen_nxt = (seen_base == '1) ? seen_base : seen_base + 1'b1;
    end
  end

  // window bytes of an old buffer are never compared, so no reset needed
  always_ff @(posedge clk) begin
    window_r <= window_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= '0;
    end else begin
      seen_r <= seen_nxt;
    end
  end

  assign window     = window_r;
  assign bytes_seen = seen_r;

endmodule

/* src/wmps_match.sv */
// Parallel wildcard compare of the window against all active patterns.
// Depends on wmps_pkg; purely combinational.
module wmps_match #(
  parameter int MAX_PATTERN_BYTES = wmps_pkg::DEF_MAX_PATTERN_BYTES,
  parameter int NUM_PATTERNS      = wmps_pkg::DEF_NUM_PATTERNS,
  parameter int OFFSET_BITS       = wmps_pkg::DEF_OFFSET_BITS
) (
  input  logic [MAX_PATTERN_BYTES-1:0][7:0] window,
  input  logic [OFFSET_BITS-1:0]            bytes_seen,
  input  wmps_pkg::cfg_bundle_t             cfg,
  output wmps_pkg::match_result_t           result
);

  localparam int EXT_BITS = (OFFSET_BITS > wmps_pkg::OUT_OFFSET_BITS) ?
                            OFFSET_BITS : wmps_pkg::OUT_OFFSET_BITS;
  localparam logic [wmps_pkg::LEN_BITS-1:0] MAX_LEN =
    wmps_pkg::LEN_BITS'(MAX_PATTERN_BYTES);
  localparam logic [wmps_pkg::COUNT_BITS-1:0] MAX_CNT =
    wmps_pkg::COUNT_BITS'(NUM_PATTERNS);

  logic [wmps_pkg::COUNT_BITS-1:0]                       active;
  logic [NUM_PATTERNS-1:0][wmps_pkg::LEN_BITS-1:0]       len;
  logic [wmps_pkg::LEN_BITS-1:0]                         longest;
  logic [wmps_pkg::LEN_BITS-1:0]                         pos;
  logic [7:0]                                            pat_byte;
  logic [wmps_pkg::MASK_BITS-1:0]                        mask;
  logic                                                  hit_k;
  logic                                                  tested;
  logic [OFFSET_BITS-1:0]                                diff;
  logic [EXT_BITS-1:0]                                   diff_ext;

  always_comb begin
    active = (cfg.count > MAX_CNT) ? MAX_CNT : cfg.count;

    longest = 4'd1;
    for (int k = 0; k < NUM_PATTERNS; k++) begin
      len[k] = cfg.lengths[wmps_pkg::LEN_BITS*k +: wmps_pkg::LEN_BITS];
      if (len[k] > MAX_LEN) len[k] = MAX_LEN;
      if (wmps_pkg::COUNT_BITS'(k) < active && len[k] > longest) longest = len[k];
    end

    tested = bytes_seen >= OFFSET_BITS'(longest);

    // window entry w lines up with pattern byte longest-1-w
    mask     = '0;
    pos      = '0;
    pat_byte = '0;
    for (int k = 0; k < NUM_PATTERNS; k++) begin
      hit_k = wmps_pkg::COUNT_BITS'(k) < active;
      for (int w = 0; w < MAX_PATTERN_BYTES; w++) begin
        pos = longest - 4'd1 - wmps_pkg::LEN_BITS'(w);
        pat_byte = cfg.patterns[k][{pos[2:0], 3'b000} +: 8];
        if (wmps_pkg::LEN_BITS'(w) < longest && pos < len[k] &&
            pat_byte != window[w] && pat_byte != wmps_pkg::WILDCARD_BYTE) begin
          hit_k = 1'b0;
        end
      end
      mask[k] = hit_k && tested;
    end

    diff     = bytes_seen - OFFSET_BITS'(longest);
    diff_ext = EXT_BITS'(diff);
  end

  assign result.hit    = mask != '0;
  assign result.mask   = mask;
  assign result.offset = diff_ext[wmps_pkg::OUT_OFFSET_BITS-1:0];

endmodule

/* src/wildcard_multi_pattern_scanner.sv */
// Top level of the wildcard multi-pattern scanner: handshake, stage control
// and result register. Depends on wmps_pkg, wmps_cfg_regs, wmps_window, wmps_match.
//
// Takes one byte per cycle, sustained, with no gaps, unless in_stall holds the input
// while a result waits on out_stall. An accepted byte enters the window register and
// byte counter. When the window stage moves on, the whole window is compared against
// every active pattern in parallel and the result register is loaded, so results are
// registered on the outputs. Positions where no pattern matches give
// no transaction. The result register and the window stage hold one transaction
// each, so one more byte is still taken while a result waits on out_stall.
// Patterns may be rewritten only while the block is idle.
module wildcard_multi_pattern_scanner #(
  parameter int MAX_PATTERN_BYTES = wmps_pkg::DEF_MAX_PATTERN_BYTES,
  parameter int NUM_PATTERNS      = wmps_pkg::DEF_NUM_PATTERNS,
  parameter int OFFSET_BITS       = wmps_pkg::DEF_OFFSET_BITS
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [wmps_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [wmps_pkg::CFG_DATA_BITS-1:0]   cfg_wdata,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [7:0]                           in_data_byte,
  input  logic                                 in_start_of_buffer,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [wmps_pkg::MASK_BITS-1:0]       out_match_mask,
  output logic [wmps_pkg::OUT_OFFSET_BITS-1:0] out_match_offset
);

  wmps_pkg::cfg_bundle_t             cfg;
  wmps_pkg::match_result_t           result;
  logic [MAX_PATTERN_BYTES-1:0][7:0] window;
  logic [OFFSET_BITS-1:0]            bytes_seen;

  logic accept;
  logic advance;
  logic stage_valid_r, stage_valid_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [wmps_pkg::MASK_BITS-1:0]       out_mask_r, out_mask_nxt;
  logic [wmps_pkg::OUT_OFFSET_BITS-1:0] out_offset_r, out_offset_nxt;

  wmps_cfg_regs #(
    .NUM_PATTERNS(NUM_PATTERNS)
  ) u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .cfg      (cfg)
  );

  wmps_window #(
    .MAX_PATTERN_BYTES(MAX_PATTERN_BYTES),
    .OFFSET_BITS      (OFFSET_BITS)
  ) u_window (
    .clk            (clk),
    .rst_n          (rst_n),
    .accept         (accept),
    .data_byte      (in_data_byte),
    .start_of_buffer(in_start_of_buffer),
    .window         (window),
    .bytes_seen     (bytes_seen)
  );

  wmps_match #(
    .MAX_PATTERN_BYTES(MAX_PATTERN_BYTES),
    .NUM_PATTERNS     (NUM_PATTERNS),
    .OFFSET_BITS      (OFFSET_BITS)
  ) u_match (
    .window    (window),
    .bytes_seen(bytes_seen),
    .cfg       (cfg),
    .result    (result)
  );

  // window stage moves on whenever the result register is free or draining
  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = stage_valid_r && !advance;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    stage_valid_nxt = stage_valid_r;
    out_valid_nxt   = out_valid_r;
    out_mask_nxt    = out_mask_r;
    out_offset_nxt  = out_offset_r;
    if (advance) begin
      stage_valid_nxt = 1'b0;
      out_valid_nxt   = stage_valid_r && result.hit;
      out_mask_nxt    = result.mask;
      out_offset_nxt  = result.offset;
    end
    if (accept) stage_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_valid_r <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      stage_valid_r <= stage_valid_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_mask_r   <= out_mask_nxt;
    out_offset_r <= out_offset_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_match_mask   = out_mask_r;
  assign out_match_offset = out_offset_r;

endmodule

/* verif/tb.sv */
// Self-checking bench for wildcard_multi_pattern_scanner: directed and random byte streams,
// checked against an in-bench scanner model, with random idle bursts on both channels.
// Depends on wmps_pkg and the scanner RTL under src.
module tb;

  localparam int ITEM_TARGET  = 900;
  localparam int QUIET_FROM   = 760;
  localparam int DRAIN_CYCLES = 6;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int MAX_REPORTS  = 20;
  localparam int MAX_LEN      = wmps_pkg::DEF_MAX_PATTERN_BYTES;
  localparam int MAX_ACTIVE   = wmps_pkg::DEF_NUM_PATTERNS;
  // first index past the register file; writes there must be ignored
  localparam logic [wmps_pkg::CFG_INDEX_BITS-1:0] CFG_IDX_SPARE = 3'd6;

  typedef struct {
    logic [7:0] data_byte;
    logic       start_of_buffer;
  } scan_byte_t;

  typedef struct {
    logic [wmps_pkg::MASK_BITS-1:0]       mask;
    logic [wmps_pkg::OUT_OFFSET_BITS-1:0] offset;
  } hit_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [wmps_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [wmps_pkg::CFG_DATA_BITS-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] in_data_byte = '0;
  logic in_start_of_buffer = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [wmps_pkg::MASK_BITS-1:0] out_match_mask;
  logic [wmps_pkg::OUT_OFFSET_BITS-1:0] out_match_offset;

  // scanner model state and its copy of the registers
  logic [7:0]  win [MAX_LEN];
  logic [31:0] seen = '0;
  logic [wmps_pkg::PATTERN_BITS-1:0] pat [wmps_pkg::PATTERN_SLOTS];
  logic [wmps_pkg::LENGTHS_BITS-1:0] lens = '0;
  logic [wmps_pkg::COUNT_BITS-1:0]   cnt = '0;

  scan_byte_t byte_q[$];
  hit_t       match_q[$];
  scan_byte_t next_item;
  hit_t       pending_hit;

  bit quiet = 1'b0;
  int gap_left = 0;
  int stall_left = 0;
  int errors = 0;
  int results_seen = 0;
  int bytes_taken = 0;
  int pushed = 0;
  int cycles = 0;

  always #5 clk = ~clk;

  wildcard_multi_pattern_scanner dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_data_byte       (in_data_byte),
    .in_start_of_buffer (in_start_of_buffer),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_match_mask     (out_match_mask),
    .out_match_offset   (out_match_offset)
  );

  function automatic int unsigned eff_len(input int unsigned k);
    int unsigned n;
    n = lens[4*k +: 4];
    return (n > MAX_LEN) ? MAX_LEN : n;
  endfunction

  function automatic int unsigned active_patterns();
    return (cnt > MAX_ACTIVE) ? MAX_ACTIVE : cnt;
  endfunction

  // Shift one byte into the window and queue the match it completes, if any.
  function automatic void scan_byte(input logic [7:0] b, input logic sob);
    int unsigned longest, act, k, j, i;
    logic [wmps_pkg::MASK_BITS-1:0] mask;
    logic ok;
    logic [7:0] pb;
    hit_t h;
    if (sob) seen = '0;
    for (i = MAX_LEN - 1; i > 0; i--) win[i] = win[i-1];
    win[0] = b;
    if (seen != 32'hFFFF_FFFF) seen = seen + 1;
    act = active_patterns();
    longest = 1;
    for (k = 0; k < act; k++)
      if (eff_len(k) > longest) longest = eff_len(k);
    if (seen < longest) return;
    mask = '0;
    for (k = 0; k < act; k++) begin
      ok = 1'b1;
      for (j = 0; j < eff_len(k); j++) begin
        pb = pat[k][8*j +: 8];
        if (pb != win[longest-1-j] && pb != wmps_pkg::WILDCARD_BYTE) ok = 1'b0;
      end
      mask[k] = ok;
    end
    if (mask != '0) begin
      h.mask = mask;
      h.offset = seen - 32'(longest);
      match_q.insert(match_q.size(), h);
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    errors++;
    if (errors <= MAX_REPORTS)
      $display("mismatch on result %0d: %s got 0x%0h, want 0x%0h",
               results_seen, what, got, want);
  endtask

  // Driver: one transaction per accept, random idle bursts between them.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall) begin
        scan_byte(in_data_byte, in_start_of_buffer);
        bytes_taken++;
      end
      if (!(in_valid && in_stall)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (byte_q.size() > 0) begin
          next_item = byte_q.pop_front();
          in_data_byte <= next_item.data_byte;
          in_start_of_buffer <= next_item.start_of_buffer;
          in_valid <= 1'b1;
          if (!quiet && $urandom_range(0, 11) == 0) gap_left = $urandom_range(1, 8);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each accepted result, stall in random bursts.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (match_q.size() == 0) begin
          report_mismatch("unexpected result, mask", out_match_mask, 0);
        end else begin
          pending_hit = match_q.pop_front();
          if (out_match_mask !== pending_hit.mask)
            report_mismatch("match_mask", out_match_mask, pending_hit.mask);
          if (out_match_offset !== pending_hit.offset)
            report_mismatch("match_offset", out_match_offset, pending_hit.offset);
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(0, 7);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, match_q.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  function automatic logic [7:0] alpha_byte();
    return ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(97, 100));
  endfunction

  function automatic logic new_buffer();
    return $urandom_range(0, 39) == 0;
  endfunction

  task automatic push_byte(input logic [7:0] b, input logic sob);
    scan_byte_t it;
    it.data_byte = b;
    it.start_of_buffer = sob;
    byte_q.insert(byte_q.size(), it);
    pushed++;
  endtask

  task automatic cfg_write(input logic [wmps_pkg::CFG_INDEX_BITS-1:0] idx,
                           input logic [63:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      wmps_pkg::CFG_IDX_PATTERN_ZERO, wmps_pkg::CFG_IDX_PATTERN_ONE,
      wmps_pkg::CFG_IDX_PATTERN_TWO, wmps_pkg::CFG_IDX_PATTERN_THREE: pat[idx[1:0]] = val;
      wmps_pkg::CFG_IDX_LENGTHS: lens = val[wmps_pkg::LENGTHS_BITS-1:0];
      wmps_pkg::CFG_IDX_COUNT:   cnt = val[wmps_pkg::COUNT_BITS-1:0];
      default: ;
    endcase
  endtask

  task automatic load_config(input logic [3:0][63:0] p, input logic [15:0] l,
                             input logic [2:0] c);
    cfg_write(CFG_IDX_SPARE + 3'($urandom_range(0, 1)), {$urandom, $urandom});
    cfg_write(wmps_pkg::CFG_IDX_PATTERN_ZERO, p[0]);
    cfg_write(wmps_pkg::CFG_IDX_PATTERN_ONE, p[1]);
    cfg_write(wmps_pkg::CFG_IDX_PATTERN_TWO, p[2]);
    cfg_write(wmps_pkg::CFG_IDX_PATTERN_THREE, p[3]);
    cfg_write(wmps_pkg::CFG_IDX_LENGTHS, {48'h0, l});
    cfg_write(wmps_pkg::CFG_IDX_COUNT, {61'h0, c});
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Sender holds off until the pipeline is empty and every match has arrived.
  task automatic wait_idle();
    @(negedge clk);
    while (byte_q.size() != 0 || in_valid || match_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic random_config();
    logic [3:0][63:0] p;
    logic [15:0] l;
    logic [2:0] c;
    int unsigned k, j;
    for (k = 0; k < 4; k++) begin
      if ($urandom_range(0, 7) == 0) begin
        p[k] = {$urandom, $urandom};
      end else begin
        for (j = 0; j < 8; j++)
          p[k][8*j +: 8] = ($urandom_range(0, 5) == 0) ? wmps_pkg::WILDCARD_BYTE :
                                                         alpha_byte();
      end
      case ($urandom_range(0, 9))
        0: l[4*k +: 4] = 4'd0;
        1: l[4*k +: 4] = 4'($urandom_range(9, 15));
        2, 3: l[4*k +: 4] = 4'($urandom_range(5, 8));
        default: l[4*k +: 4] = 4'($urandom_range(1, 4));
      endcase
    end
    c = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(1, 4));
    load_config(p, l, c);
  endtask

  // Mostly planted pattern copies (wildcards filled at random), some cut short,
  // the rest filler bytes; buffer restarts fall anywhere.
  task automatic random_stream(input int unsigned n);
    int unsigned made, k, j, len, act, fill;
    logic [7:0] b;
    made = 0;
    act = active_patterns();
    while (made < n) begin
      if ($urandom_range(0, 9) < 6 && act > 0) begin
        k = $urandom_range(0, act - 1);
        len = eff_len(k);
        if ($urandom_range(0, 7) == 0) len = $urandom_range(0, len);
        for (j = 0; j < len; j++) begin
          b = pat[k][8*j +: 8];
          if (b == wmps_pkg::WILDCARD_BYTE) b = 8'($urandom_range(0, 255));
          push_byte(b, new_buffer());
          made++;
        end
      end else begin
        fill = $urandom_range(1, 4);
        for (j = 0; j < fill; j++) begin
          push_byte(alpha_byte(), new_buffer());
          made++;
        end
      end
    end
  endtask

  initial begin
    logic [3:0][63:0] p;
    int i;
    int phase_no;
    for (i = 0; i < MAX_LEN; i++) win[i] = '0;
    for (i = 0; i < wmps_pkg::PATTERN_SLOTS; i++) pat[i] = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // "A?C", a zero-length pattern, eight 0xFF, and an over-long all-zero
    // pattern; count above the number of slots.
    p[0] = 64'h0000_0000_0043_3F41;
    p[1] = 64'h0123_4567_89AB_CDEF;
    p[2] = 64'hFFFF_FFFF_FFFF_FFFF;
    p[3] = 64'h0;
    load_config(p, 16'hF803, 3'd7);
    for (i = 0; i < 8; i++) push_byte(8'h00, i == 0);
    for (i = 0; i < 8; i++) push_byte(8'hFF, 1'b0);
    // restart over a stale window, wildcard byte in the data itself
    push_byte(8'h41, 1'b1);
    push_byte(8'h80, 1'b0);
    push_byte(8'h43, 1'b0);
    push_byte(wmps_pkg::WILDCARD_BYTE, 1'b0);
    push_byte(8'h01, 1'b0);
    push_byte(8'h7F, 1'b0);
    push_byte(8'hFE, 1'b0);
    push_byte(8'h55, 1'b0);
    wait_idle();

    phase_no = 0;
    while (pushed < ITEM_TARGET) begin
      if (pushed >= QUIET_FROM) quiet = 1'b1;
      case (phase_no)
        0: load_config('1, 16'hFFFF, 3'd4);
        1: load_config('0, 16'h0000, 3'd0);
        2: load_config('0, 16'h0000, 3'd4);
        default: random_config();
      endcase
      random_stream($urandom_range(40, 100));
      wait_idle();
      phase_no++;
    end

    $display("Scanned %0d bytes under %0d pattern setups; %0d match results checked.",
             bytes_taken, phase_no + 1, results_seen);
    $display("Setups took in wildcards, zero and over-long lengths, counts 0 to 7, %s",
             "buffer restarts and writes to unused register indexes.");
    if (errors == 0 && match_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

/* files.f */
src/wmps_pkg.sv
src/wmps_cfg_regs.sv
src/wmps_window.sv
src/wmps_match.sv
src/wildcard_multi_pattern_scanner.sv
verif/tb.sv
